FILE: hdl/assert_macros.svh
// Assertion helpers used by the RTL datapath.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_ALWAYS(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("assertion failed");
`define ASSERT_IMPLIES(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("assertion failed");
`else
`define ASSERT_ALWAYS(lbl, clk, rstn, prop)
`define ASSERT_IMPLIES(lbl, clk, rstn, ante, cons)
`endif
`endif

FILE: hdl/cbs_pkg.sv
package cbs_pkg;

  localparam int unsigned MaxJobsDef   = 32;
  localparam int unsigned MaxBurstsDef = 32;
  localparam int unsigned TimeBitsDef  = 32;

  localparam logic [15:0] SLICE_RESET = 16'd25;

  localparam logic [1:0] OP_HDR   = 2'd0;
  localparam logic [1:0] OP_BURST = 2'd1;
  localparam logic [1:0] OP_TICK  = 2'd2;

  localparam logic [1:0] MODE_FCFS = 2'd0;

  localparam logic REG_MODE  = 1'b0;
  localparam logic REG_SLICE = 1'b1;

  typedef struct packed {
    logic tick_start;
    logic scan_step;
    logic admit;
    logic run_chk;
    logic sel_clr;
    logic sel_step;
    logic take;
    logic rd_cpu;
    logic rd_io;
    logic calc;
    logic ret;
    logic finish;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic jobs_idle;
    logic scan_last;
    logic best_ok;
    logic can_disp;
    logic prio_sel;
    logic sel_last;
    logic out_free;
  } sts_t;

endpackage

FILE: hdl/cbs_ram.sv
module cbs_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 1024,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

FILE: hdl/cbs_ctrl.sv
module cbs_ctrl import cbs_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic [1:0] opcode_i,
  output logic       in_stall_o,
  input  sts_t       sts_i,
  output cmd_t       cmd_o
);

  typedef enum logic [3:0] {
    S_IDLE, S_SCAN, S_ADMIT, S_RUNEND, S_SEL0, S_SELS, S_TAKE,
    S_RDCPU, S_RDIO, S_CALC, S_RET, S_FIN, S_EMIT
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i && opcode_i == OP_TICK) begin
          cmd_o.tick_start = 1'b1;
          state_d = sts_i.jobs_idle ? S_EMIT : S_SCAN;
        end
      end
      S_SCAN: begin
        cmd_o.scan_step = 1'b1;
        if (sts_i.scan_last) state_d = S_ADMIT;
      end
      S_ADMIT: begin
        // admit the oldest due job, then look again
        if (sts_i.best_ok) begin
          cmd_o.admit = 1'b1;
          state_d = S_SCAN;
        end else begin
          state_d = S_RUNEND;
        end
      end
      S_RUNEND: begin
        cmd_o.run_chk = 1'b1;
        state_d = S_SEL0;
      end
      S_SEL0: begin
        if (sts_i.can_disp) begin
          cmd_o.sel_clr = 1'b1;
          state_d = sts_i.prio_sel ? S_SELS : S_TAKE;
        end else begin
          state_d = S_FIN;
        end
      end
      S_SELS: begin
        cmd_o.sel_step = 1'b1;
        if (sts_i.sel_last) state_d = S_TAKE;
      end
      S_TAKE: begin
        cmd_o.take = 1'b1;
        state_d = S_RDCPU;
      end
      S_RDCPU: begin
        cmd_o.rd_cpu = 1'b1;
        state_d = S_RDIO;
      end
      S_RDIO: begin
        cmd_o.rd_io = 1'b1;
        state_d = S_CALC;
      end
      S_CALC: begin
        cmd_o.calc = 1'b1;
        state_d = S_RET;
      end
      S_RET: begin
        cmd_o.ret = 1'b1;
        state_d = S_FIN;
      end
      S_FIN: begin
        cmd_o.finish = 1'b1;
        state_d = S_EMIT;
      end
      S_EMIT: begin
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign in_stall_o = (state_q != S_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

FILE: hdl/cbs_datapath.sv
`include "assert_macros.svh"
module cbs_datapath import cbs_pkg::*; #(
  parameter int unsigned MAX_JOBS   = MaxJobsDef,
  parameter int unsigned MAX_BURSTS = MaxBurstsDef,
  parameter int unsigned TIME_BITS  = TimeBitsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_fire_i,
  input  logic [1:0]  opcode_i,
  input  logic [15:0] job_id_i,
  input  logic [7:0]  priority_req_i,
  input  logic [15:0] arrival_i,
  input  logic [15:0] burst_i,
  input  logic [1:0]  mode_i,
  input  logic [15:0] time_slice_i,
  input  cmd_t        cmd_i,
  output sts_t        sts_o,
  input  logic        out_stall_i,
  output logic        out_valid_o,
  output logic        dispatched_o,
  output logic [15:0] run_job_id_o,
  output logic [31:0] start_time_o,
  output logic        all_done_o,
  output logic [31:0] total_waiting_o,
  output logic [31:0] total_turnaround_o
);

  localparam int unsigned JW    = (MAX_JOBS > 1) ? $clog2(MAX_JOBS) : 1;
  localparam int unsigned CW    = $clog2(MAX_JOBS + 1);
  localparam int unsigned NW    = $clog2(MAX_BURSTS + 1);
  localparam int unsigned DEPTH = MAX_JOBS * MAX_BURSTS;
  localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  // per-job state
  logic [15:0]          id_q    [MAX_JOBS];
  logic [7:0]           prio_q  [MAX_JOBS];
  logic [NW-1:0]        bcnt_q  [MAX_JOBS];
  logic [NW-1:0]        cidx_q  [MAX_JOBS];
  logic [15:0]          crem_q  [MAX_JOBS];
  logic                 pre_q   [MAX_JOBS];
  logic [TIME_BITS-1:0] rtime_q [MAX_JOBS];
  logic                 rpend_q [MAX_JOBS];
  logic [15:0]          rstamp_q[MAX_JOBS];
  logic [JW-1:0]        fifo_q  [MAX_JOBS];

  logic [CW-1:0]        rcnt_q, jrem_q, jcnt_q;
  logic [JW-1:0]        run_slot_q, scan_q, best_q, selpos_q, dslot_q;
  logic                 busy_q, best_ok_q, ret_cand_q;
  logic [TIME_BITS-1:0] run_end_q, now_q;
  logic [15:0]          stamp_q, best_age_q, cpu_q, io_q;
  logic [7:0]           selprio_q;
  logic [31:0]          wsum_q, tsum_q;
  logic                 res_disp_q, out_valid_q;
  logic [15:0]          res_id_q;
  logic [31:0]          res_start_q;
  logic                 o_disp_q, o_done_q;
  logic [15:0]          o_id_q;
  logic [31:0]          o_start_q, o_wsum_q, o_tsum_q;

  logic [JW-1:0]  last_slot, hdr_slot, rd_slot, fifo_ra, fifo_rd;
  logic [7:0]     sel_prio;
  logic           due, best_upd, hdr_ok, burst_ok, fin_run, push, retire;
  logic [15:0]    age, bval, rem0, slice, run, rem;
  logic [NW:0]    pos_rd;
  logic [NW-1:0]  cnt_rd;
  logic [TIME_BITS:0] run_sum, ret_sum, now_sum;
  logic [TIME_BITS-1:0] run_end_n;
  logic [32:0]    ws, ts, tb;
  logic           ram_we;
  logic [AW-1:0]  ram_waddr, ram_raddr;
  logic [15:0]    ram_rdata;

  assign last_slot = JW'(jcnt_q - CW'(1));
  assign hdr_slot  = JW'(jcnt_q);

  always_comb begin
    if (cmd_i.scan_step) begin
      rd_slot = scan_q;
    end else if (cmd_i.admit) begin
      rd_slot = best_q;
    end else if (cmd_i.run_chk) begin
      rd_slot = run_slot_q;
    end else if (cmd_i.rd_cpu || cmd_i.rd_io || cmd_i.calc) begin
      rd_slot = dslot_q;
    end else begin
      rd_slot = last_slot;
    end
  end

  always_comb begin
    if (cmd_i.take) begin
      fifo_ra = selpos_q;
    end else if (cmd_i.sel_clr) begin
      fifo_ra = '0;
    end else begin
      fifo_ra = scan_q;
    end
  end

  assign fifo_rd  = fifo_q[fifo_ra];
  assign sel_prio = prio_q[fifo_rd];

  assign due      = rpend_q[rd_slot] && (rtime_q[rd_slot] <= now_q);
  assign age      = stamp_q - rstamp_q[rd_slot];
  assign best_upd = due && (!best_ok_q || age > best_age_q);
  assign pos_rd   = {cidx_q[rd_slot], 1'b0};
  assign cnt_rd   = bcnt_q[rd_slot];

  // when now reaches a run's end the job retires, or requeues if preempted
  assign fin_run = cmd_i.run_chk && busy_q && (now_q >= run_end_q);
  always_comb begin
    push   = 1'b0;
    retire = 1'b0;
    if (cmd_i.admit) begin
      retire = (cnt_rd == '0);
      push   = (cnt_rd != '0);
    end else if (fin_run) begin
      retire = (pos_rd >= (NW+1)'(cnt_rd));
      push   = !retire && pre_q[rd_slot];
    end
  end

  assign hdr_ok   = in_fire_i && opcode_i == OP_HDR && jcnt_q < CW'(MAX_JOBS);
  assign burst_ok = in_fire_i && opcode_i == OP_BURST && jcnt_q != '0 &&
                    cnt_rd < NW'(MAX_BURSTS);
  assign bval     = (burst_i == '0) ? 16'd1 : burst_i;

  // dispatch arithmetic
  assign rem0  = pre_q[rd_slot] ? crem_q[rd_slot]
               : ((pos_rd < (NW+1)'(cnt_rd)) ? cpu_q : 16'd1);
  assign slice = (time_slice_i == '0) ? 16'd1 : time_slice_i;
  assign run   = (mode_i != MODE_FCFS && slice < rem0) ? slice : rem0;
  assign rem   = rem0 - run;
  assign run_sum   = {1'b0, now_q} + (TIME_BITS+1)'(run);
  assign run_end_n = run_sum[TIME_BITS] ? '1 : run_sum[TIME_BITS-1:0];
  assign ret_sum   = {1'b0, run_end_q} + (TIME_BITS+1)'(io_q);
  assign now_sum   = {1'b0, now_q} + (TIME_BITS+1)'(1);

  assign ws = {1'b0, wsum_q} + 33'(rcnt_q);
  assign ts = {1'b0, tsum_q} + 33'(rcnt_q);
  assign tb = {1'b0, tsum_q} + 33'(bval);

  assign ram_we    = burst_ok;
  assign ram_waddr = AW'(AW'(last_slot) * AW'(MAX_BURSTS) + AW'(cnt_rd));
  assign ram_raddr = AW'(AW'(rd_slot) * AW'(MAX_BURSTS) + AW'(pos_rd) + AW'(cmd_i.rd_io));

  cbs_ram #(.WIDTH(16), .DEPTH(DEPTH)) u_bursts (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (bval),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < MAX_JOBS; i++) begin
        bcnt_q[i]  <= '0;
        cidx_q[i]  <= '0;
        pre_q[i]   <= 1'b0;
        rpend_q[i] <= 1'b0;
      end
      rcnt_q      <= '0;
      jrem_q      <= '0;
      jcnt_q      <= '0;
      run_slot_q  <= '0;
      busy_q      <= 1'b0;
      run_end_q   <= '1;
      now_q       <= '0;
      stamp_q     <= '0;
      wsum_q      <= '0;
      tsum_q      <= '0;
      scan_q      <= '0;
      best_ok_q   <= 1'b0;
      ret_cand_q  <= 1'b0;
      out_valid_q <= 1'b0;
      res_disp_q  <= 1'b0;
    end else begin
      if (hdr_ok) begin
        bcnt_q[hdr_slot]  <= '0;
        cidx_q[hdr_slot]  <= '0;
        pre_q[hdr_slot]   <= 1'b0;
        rpend_q[hdr_slot] <= 1'b1;
        jcnt_q  <= jcnt_q + CW'(1);
        jrem_q  <= jrem_q + CW'(1);
        stamp_q <= stamp_q + 16'd1;
      end
      if (burst_ok) begin
        bcnt_q[last_slot] <= cnt_rd + NW'(1);
        tsum_q <= tb[32] ? '1 : tb[31:0];
      end
      if (cmd_i.tick_start || cmd_i.admit) begin
        scan_q    <= '0;
        best_ok_q <= 1'b0;
      end
      if (cmd_i.tick_start) begin
        res_disp_q <= 1'b0;
      end
      if (cmd_i.scan_step) begin
        scan_q <= scan_q + JW'(1);
        if (best_upd) best_ok_q <= 1'b1;
      end
      if (cmd_i.admit) begin
        rpend_q[rd_slot] <= 1'b0;
      end
      if (fin_run) begin
        busy_q <= 1'b0;
      end
      if (push && rcnt_q < CW'(MAX_JOBS)) begin
        rcnt_q <= rcnt_q + CW'(1);
      end
      if (retire && jrem_q != '0) begin
        jrem_q <= jrem_q - CW'(1);
      end
      if (cmd_i.sel_clr) begin
        scan_q <= JW'(1);
      end
      if (cmd_i.sel_step) begin
        scan_q <= scan_q + JW'(1);
      end
      if (cmd_i.take) begin
        rcnt_q <= rcnt_q - CW'(1);
      end
      if (cmd_i.rd_cpu) begin
        res_disp_q <= 1'b1;
      end
      if (cmd_i.calc) begin
        pre_q[rd_slot] <= (rem != '0);
        run_end_q  <= run_end_n;
        run_slot_q <= rd_slot;
        busy_q     <= 1'b1;
        ret_cand_q <= (rem == '0) &&
                      ((NW+2)'(pos_rd) + (NW+2)'(2) < (NW+2)'(cnt_rd));
        if (rem == '0) begin
          cidx_q[rd_slot] <= cidx_q[rd_slot] + NW'(1);
        end
      end
      if (cmd_i.ret && ret_cand_q) begin
        rpend_q[dslot_q] <= 1'b1;
        stamp_q <= stamp_q + 16'd1;
      end
      if (cmd_i.finish) begin
        wsum_q <= ws[32] ? '1 : ws[31:0];
        tsum_q <= ts[32] ? '1 : ts[31:0];
        now_q  <= now_sum[TIME_BITS] ? '1 : now_sum[TIME_BITS-1:0];
      end
      if (cmd_i.emit) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload state
  always_ff @(posedge clk_i) begin
    if (hdr_ok) begin
      id_q[hdr_slot]     <= job_id_i;
      prio_q[hdr_slot]   <= priority_req_i;
      crem_q[hdr_slot]   <= '0;
      rtime_q[hdr_slot]  <= TIME_BITS'(arrival_i);
      rstamp_q[hdr_slot] <= stamp_q;
    end
    if (cmd_i.scan_step && best_upd) begin
      best_q     <= scan_q;
      best_age_q <= age;
    end
    if (push && rcnt_q < CW'(MAX_JOBS)) begin
      fifo_q[JW'(rcnt_q)] <= rd_slot;
    end
    if (cmd_i.sel_clr) begin
      selpos_q  <= '0;
      selprio_q <= sel_prio;
    end
    if (cmd_i.sel_step && sel_prio < selprio_q) begin
      selpos_q  <= scan_q;
      selprio_q <= sel_prio;
    end
    if (cmd_i.take) begin
      dslot_q <= fifo_rd;
      for (int i = 0; i + 1 < MAX_JOBS; i++) begin
        if (JW'(i) >= selpos_q) fifo_q[i] <= fifo_q[i+1];
      end
    end
    if (cmd_i.tick_start) begin
      res_id_q    <= '0;
      res_start_q <= '0;
    end
    if (cmd_i.rd_cpu) begin
      res_id_q    <= id_q[rd_slot];
      res_start_q <= 32'(now_q);
    end
    if (cmd_i.rd_io) begin
      cpu_q <= ram_rdata;
    end
    if (cmd_i.calc) begin
      io_q <= ram_rdata;
      if (rem != '0) crem_q[rd_slot] <= rem;
    end
    if (cmd_i.ret && ret_cand_q) begin
      rtime_q[dslot_q]  <= ret_sum[TIME_BITS] ? '1 : ret_sum[TIME_BITS-1:0];
      rstamp_q[dslot_q] <= stamp_q;
    end
    if (cmd_i.emit) begin
      o_disp_q  <= res_disp_q;
      o_id_q    <= res_id_q;
      o_start_q <= res_start_q;
      o_done_q  <= (jrem_q == '0) && (jcnt_q != '0);
      o_wsum_q  <= wsum_q;
      o_tsum_q  <= tsum_q;
    end
  end

  assign sts_o.jobs_idle = (jrem_q == '0);
  assign sts_o.scan_last = (CW'(scan_q) == jcnt_q - CW'(1));
  assign sts_o.best_ok   = best_ok_q;
  assign sts_o.can_disp  = !busy_q && (rcnt_q != '0);
  assign sts_o.prio_sel  = mode_i[1] && (rcnt_q > CW'(1));
  assign sts_o.sel_last  = (CW'(scan_q) == rcnt_q - CW'(1));
  assign sts_o.out_free  = !out_valid_q || !out_stall_i;

  assign out_valid_o        = out_valid_q;
  assign dispatched_o       = o_disp_q;
  assign run_job_id_o       = o_id_q;
  assign start_time_o       = o_start_q;
  assign all_done_o         = o_done_q;
  assign total_waiting_o    = o_wsum_q;
  assign total_turnaround_o = o_tsum_q;

  `ASSERT_ALWAYS(a_rcnt_le_jobs, clk_i, rst_ni, rcnt_q <= jcnt_q)
  `ASSERT_ALWAYS(a_jrem_le_jobs, clk_i, rst_ni, jrem_q <= jcnt_q)
  `ASSERT_IMPLIES(a_busy_slot, clk_i, rst_ni, busy_q, CW'(run_slot_q) < jcnt_q)
  `ASSERT_IMPLIES(a_take_nonempty, clk_i, rst_ni, cmd_i.take, rcnt_q != '0)

endmodule

FILE: hdl/cpu_burst_scheduler_sim.sv
// CPU burst scheduler.
// Input channel (in_valid_i / in_stall_o): one item per accept. Opcode 0 loads a
// job header, opcode 1 appends a burst length to the last loaded job, opcode 2
// advances time by one tick while a job remains. Headers and bursts give no
// result. A tick gives exactly one result item on the output channel
// (out_valid_o / out_stall_i) with the dispatch, the done flag and both totals.
// With J jobs loaded and S of them admitted in a tick, the admission loop scans
// all J slots S+1 times, one slot a cycle, with an admit step after each pass.
// A priority pick steps through the ready jobs. A tick with no job remaining
// skips the scan and goes straight to the emit step. The input is stalled from
// the accept of a tick until its result is emitted. The finished result sits in
// an output register; the next item is accepted while it waits, and a following
// tick holds in its last step until the receiver stops stalling. mode and
// time_slice sit on the APB port at 0x0 and 0x4.
// Reset clears all counts and the queue, sets mode to FCFS and the slice to 25;
// the burst memory needs no clearing.
module cpu_burst_scheduler_sim import cbs_pkg::*; #(
  parameter int unsigned MAX_JOBS   = MaxJobsDef,
  parameter int unsigned MAX_BURSTS = MaxBurstsDef,
  parameter int unsigned TIME_BITS  = TimeBitsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  opcode_i,
  input  logic [15:0] job_id_i,
  input  logic [7:0]  priority_req_i,
  input  logic [15:0] arrival_i,
  input  logic [15:0] burst_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        dispatched_o,
  output logic [15:0] run_job_id_o,
  output logic [31:0] start_time_o,
  output logic        all_done_o,
  output logic [31:0] total_waiting_o,
  output logic [31:0] total_turnaround_o
);

  logic [1:0]  mode_q;
  logic [15:0] slice_q;
  logic        wr_en, in_fire;
  cmd_t        cmd;
  sts_t        sts;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= MODE_FCFS;
      slice_q <= SLICE_RESET;
    end else if (wr_en) begin
      case (paddr[2])
        REG_MODE:  mode_q  <= pwdata[1:0];
        REG_SLICE: slice_q <= pwdata[15:0];
        default:   mode_q  <= mode_q;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_MODE:  prdata = 32'(mode_q);
      REG_SLICE: prdata = 32'(slice_q);
      default:   prdata = '0;
    endcase
  end

  assign in_fire = in_valid_i && !in_stall_o;

  cbs_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .opcode_i   (opcode_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  cbs_datapath #(
    .MAX_JOBS   (MAX_JOBS),
    .MAX_BURSTS (MAX_BURSTS),
    .TIME_BITS  (TIME_BITS)
  ) u_dp (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_fire_i          (in_fire),
    .opcode_i           (opcode_i),
    .job_id_i           (job_id_i),
    .priority_req_i     (priority_req_i),
    .arrival_i          (arrival_i),
    .burst_i            (burst_i),
    .mode_i             (mode_q),
    .time_slice_i       (slice_q),
    .cmd_i              (cmd),
    .sts_o              (sts),
    .out_stall_i        (out_stall_i),
    .out_valid_o        (out_valid_o),
    .dispatched_o       (dispatched_o),
    .run_job_id_o       (run_job_id_o),
    .start_time_o       (start_time_o),
    .all_done_o         (all_done_o),
    .total_waiting_o    (total_waiting_o),
    .total_turnaround_o (total_turnaround_o)
  );

endmodule

FILE: verif/cpu_burst_scheduler_sim_tb.sv
`timescale 1ns / 1ps

module cpu_burst_scheduler_sim_tb;
  import cbs_pkg::*;

  localparam logic [1:0] OP_NOP        = 2'd3;
  localparam logic [1:0] MODE_PRIO     = 2'd2;
  localparam logic [1:0] MODE_PRIO_ALT = 2'd3;
  localparam int unsigned NJOBS   = MaxJobsDef;
  localparam int unsigned NBURSTS = MaxBurstsDef;
  localparam longint unsigned TMAX = 64'hFFFF_FFFF;
  localparam int unsigned SETTLE  = 1200;

  typedef struct {
    bit        disp;
    bit [15:0] id;
    bit [31:0] start;
    bit        done;
    bit [31:0] wait_sum;
    bit [31:0] turn_sum;
  } sched_result_t;

  class sched_scoreboard;
    bit [1:0]  mode;
    bit [15:0] slice;
    bit [15:0] ids[NJOBS];
    bit [7:0]  prio[NJOBS];
    bit [15:0] bursts[NJOBS][NBURSTS];
    int unsigned bcnt[NJOBS];
    int unsigned cpu_idx[NJOBS];
    int unsigned cpu_rem[NJOBS];
    bit        preempt[NJOBS];
    longint unsigned ret_time[NJOBS];
    bit        ret_pend[NJOBS];
    bit [15:0] ret_stamp[NJOBS];
    int unsigned ready_q[$];
    int unsigned running;
    bit        busy;
    longint unsigned run_end;
    longint unsigned now;
    int unsigned remaining;
    int unsigned njobs;
    bit [15:0] stamp;
    bit [31:0] wsum;
    bit [31:0] tsum;
    sched_result_t pending_q[$];
    int unsigned errors;
    int unsigned ticks;
    int unsigned dispatches;

    function new();
      mode = MODE_FCFS;
      slice = SLICE_RESET;
      run_end = TMAX;
    endfunction

    task report(string msg);
      $display("MISMATCH @%0t: %s", $time, msg);
      errors++;
    endtask

    function longint unsigned tadd(longint unsigned a, longint unsigned b);
      return (a + b > TMAX) ? TMAX : a + b;
    endfunction

    function bit [31:0] sadd(bit [31:0] a, bit [31:0] b);
      bit [32:0] s;
      s = {1'b0, a} + b;
      return s[32] ? 32'hFFFF_FFFF : s[31:0];
    endfunction

    function void retire_job();
      if (remaining > 0) remaining--;
    endfunction

    function void admit_due();
      int best;
      bit [15:0] best_age;
      bit [15:0] age;
      forever begin
        best = -1;
        best_age = 0;
        for (int i = 0; i < njobs; i++) begin
          if (ret_pend[i] && ret_time[i] <= now) begin
            age = stamp - ret_stamp[i];
            if (best < 0 || age > best_age) begin
              best = i;
              best_age = age;
            end
          end
        end
        if (best < 0) return;
        ret_pend[best] = 0;
        if (bcnt[best] == 0) retire_job();
        else if (ready_q.size() < NJOBS) ready_q = {ready_q, best};
      end
    endfunction

    function void run_job(int unsigned s);
      int unsigned pos, rem, run, sl;
      pos = 2 * cpu_idx[s];
      if (preempt[s]) rem = cpu_rem[s];
      else rem = (pos < bcnt[s]) ? bursts[s][pos] : 1;
      preempt[s] = 0;
      sl = (slice == 0) ? 1 : slice;
      run = rem;
      if (mode != MODE_FCFS && sl < rem) run = sl;
      run_end = tadd(now, run);
      rem -= run;
      running = s;
      busy = 1;
      if (rem == 0) begin
        cpu_idx[s]++;
        // next CPU burst exists: come back after the I/O burst
        if (pos + 2 < bcnt[s]) begin
          ret_time[s] = tadd(run_end, bursts[s][pos + 1]);
          ret_pend[s] = 1;
          ret_stamp[s] = stamp;
          stamp++;
        end
      end else begin
        preempt[s] = 1;
        cpu_rem[s] = rem;
      end
    endfunction

    function void note_item(bit [1:0] op, bit [15:0] id, bit [7:0] pr, bit [15:0] arr,
                            bit [15:0] b);
      sched_result_t r;
      int unsigned s, pos;
      bit [15:0] bv;
      if (op == OP_HDR) begin
        if (njobs < NJOBS) begin
          s = njobs++;
          ids[s] = id;
          prio[s] = pr;
          bcnt[s] = 0;
          cpu_idx[s] = 0;
          cpu_rem[s] = 0;
          preempt[s] = 0;
          ret_time[s] = arr;
          ret_pend[s] = 1;
          ret_stamp[s] = stamp;
          stamp++;
          remaining++;
        end
        return;
      end
      if (op == OP_BURST) begin
        if (njobs > 0) begin
          s = njobs - 1;
          bv = (b == 0) ? 16'd1 : b;
          if (bcnt[s] < NBURSTS) begin
            bursts[s][bcnt[s]] = bv;
            bcnt[s]++;
            tsum = sadd(tsum, bv);
          end
        end
        return;
      end
      if (op == OP_NOP) return;
      r = '{default: 0};
      if (remaining > 0) begin
        admit_due();
        if (busy && now >= run_end) begin
          s = running;
          busy = 0;
          if (2 * cpu_idx[s] >= bcnt[s]) retire_job();
          else if (preempt[s] && ready_q.size() < NJOBS) ready_q = {ready_q, s};
        end
        if (!busy && ready_q.size() > 0) begin
          pos = 0;
          if (mode >= MODE_PRIO)
            for (int i = 1; i < ready_q.size(); i++)
              if (prio[ready_q[i]] < prio[ready_q[pos]]) pos = i;
          s = ready_q[pos];
          ready_q.delete(pos);
          r.disp = 1;
          r.id = ids[s];
          r.start = now[31:0];
          run_job(s);
        end
        wsum = sadd(wsum, ready_q.size());
        tsum = sadd(tsum, ready_q.size());
        now = tadd(now, 1);
      end
      r.done = (remaining == 0 && njobs > 0);
      r.wait_sum = wsum;
      r.turn_sum = tsum;
      pending_q = {pending_q, r};
      ticks++;
    endfunction

    task check_result(sched_result_t got);
      sched_result_t exp_r;
      if (pending_q.size() == 0) begin
        report("result with nothing expected");
        return;
      end
      exp_r = pending_q.pop_front();
      if (exp_r.disp) dispatches++;
      if (got.disp != exp_r.disp)
        report($sformatf("dispatched %0d exp %0d", got.disp, exp_r.disp));
      if (got.id != exp_r.id)
        report($sformatf("run_job_id %0h exp %0h", got.id, exp_r.id));
      if (got.start != exp_r.start)
        report($sformatf("start_time %0d exp %0d", got.start, exp_r.start));
      if (got.done != exp_r.done)
        report($sformatf("all_done %0d exp %0d", got.done, exp_r.done));
      if (got.wait_sum != exp_r.wait_sum)
        report($sformatf("total_waiting %0d exp %0d", got.wait_sum, exp_r.wait_sum));
      if (got.turn_sum != exp_r.turn_sum)
        report($sformatf("total_turnaround %0d exp %0d", got.turn_sum, exp_r.turn_sum));
    endtask
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        psel, penable, pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid_i;
  logic        in_stall_o;
  logic [1:0]  opcode_i;
  logic [15:0] job_id_i;
  logic [7:0]  priority_req_i;
  logic [15:0] arrival_i;
  logic [15:0] burst_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic        dispatched_o;
  logic [15:0] run_job_id_o;
  logic [31:0] start_time_o;
  logic        all_done_o;
  logic [31:0] total_waiting_o;
  logic [31:0] total_turnaround_o;

  sched_scoreboard sb = new();
  bit calm_in;
  int unsigned items_sent;

  cpu_burst_scheduler_sim u_dut (.*);

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #50ms;
    $display("Verification failed");
    $finish;
  end

  task automatic send(bit [1:0] op, bit [15:0] id = 0, bit [7:0] pr = 0,
                      bit [15:0] arr = 0, bit [15:0] b = 1);
    int unsigned gap;
    gap = calm_in ? 0 : $urandom_range(0, 12);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    opcode_i       <= op;
    job_id_i       <= id;
    priority_req_i <= pr;
    arrival_i      <= arr;
    burst_i        <= b;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_item(op, id, pr, arr, b);
    items_sent++;
  endtask

  // pause the sender until every tick has answered
  task automatic drain(int unsigned extra);
    in_valid_i <= 1'b0;
    while (sb.pending_q.size() > 0) @(posedge clk_i);
    repeat (extra) @(posedge clk_i);
  endtask

  task automatic apb_write(logic reg_idx, bit [15:0] val);
    logic [31:0] rd;
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= {reg_idx, 2'b00}; pwdata <= 32'(val);
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    pwrite <= 1'b0; penable <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    rd = prdata;
    psel <= 1'b0; penable <= 1'b0;
    if (reg_idx == REG_MODE) sb.mode = val[1:0];
    else sb.slice = val;
    if (rd != (reg_idx == REG_MODE ? {30'd0, val[1:0]} : {16'd0, val}))
      sb.report($sformatf("reg %0d read %0h", reg_idx, rd));
  endtask

  task automatic tick_until_idle(int unsigned cap);
    int unsigned n;
    n = 0;
    while (sb.remaining > 0 && n < cap) begin
      if ($urandom_range(0, 19) == 0)
        send(OP_NOP, 16'($urandom), 8'($urandom), 16'($urandom), 16'($urandom));
      send(OP_TICK, 16'($urandom), 8'($urandom), 16'($urandom), 16'($urandom));
      n++;
    end
  endtask

  task automatic load_job(bit [15:0] arr, int unsigned nb);
    bit [7:0] pr;
    bit [15:0] b;
    pr = $urandom_range(0, 1) ? 8'($urandom_range(0, 3)) : 8'($urandom_range(0, 255));
    send(OP_HDR, 16'($urandom), pr, arr, 16'($urandom));
    for (int i = 0; i < nb; i++) begin
      b = ($urandom_range(0, 19) == 0) ? 16'd0 :
          ($urandom_range(0, 9) < 7) ? 16'($urandom_range(1, 6)) :
                                       16'($urandom_range(1, 40));
      send(OP_BURST, 16'($urandom), 8'($urandom), 16'($urandom), b);
    end
  endtask

  // receiver: random stall before each item, checks every accepted result
  initial begin
    sched_result_t got;
    int unsigned gap, nres;
    bit calm_out;
    out_stall_i <= 1'b1;
    @(posedge rst_ni);
    nres = 0;
    forever begin
      if (nres % 40 == 0) calm_out = ($urandom_range(0, 3) == 0);
      gap = calm_out ? 0 : $urandom_range(0, 12);
      if (gap > 0) begin
        out_stall_i <= 1'b1;
        repeat (gap) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (!out_valid_o);
      got.disp = dispatched_o;
      got.id = run_job_id_o;
      got.start = start_time_o;
      got.done = all_done_o;
      got.wait_sum = total_waiting_o;
      got.turn_sum = total_turnaround_o;
      sb.check_result(got);
      nres++;
    end
  end

  initial begin
    bit [15:0] slices[6];
    bit [15:0] arr;
    int unsigned phase;
    slices = '{16'd1, 16'd2, 16'd65535, 16'd0, 16'd3, 16'd5};
    rst_ni <= 1'b0;
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0; paddr <= '0; pwdata <= '0;
    in_valid_i <= 1'b0; opcode_i <= OP_NOP; job_id_i <= '0;
    priority_req_i <= '0; arrival_i <= '0; burst_i <= '0;
    calm_in = 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // no job yet: ignored opcode, orphan burst, empty tick
    send(OP_NOP, 16'hFFFF, 8'hFF, 16'hFFFF, 16'hFFFF);
    send(OP_BURST, 0, 0, 0, 16'd9);
    send(OP_TICK);
    drain(SETTLE);
    apb_write(REG_MODE, 16'(MODE_PRIO));
    apb_write(REG_SLICE, 16'd1);
    // job with no burst, zero burst, equal priorities
    send(OP_HDR, 16'hFFFF, 8'hFF, 16'd0);
    send(OP_HDR, 16'h0000, 8'h00, 16'd0);
    send(OP_BURST, 0, 0, 0, 16'd1);
    send(OP_BURST, 0, 0, 0, 16'd0);
    send(OP_BURST, 0, 0, 0, 16'd3);
    send(OP_HDR, 16'h5A5A, 8'h00, 16'd1);
    send(OP_BURST, 0, 0, 0, 16'd2);
    tick_until_idle(60);
    send(OP_TICK);
    drain(SETTLE);

    phase = 0;
    while (sb.njobs < 29) begin
      apb_write(REG_MODE, 16'(phase[1:0]));
      apb_write(REG_SLICE, slices[phase % 6]);
      calm_in = ($urandom_range(0, 3) == 0);
      for (int j = 0; j < 3 + $urandom_range(0, 1) && sb.njobs < 29; j++) begin
        // sometimes the arrival is already in the past
        arr = ($urandom_range(0, 9) == 0) ? 16'd0 :
              16'(sb.now[15:0] + 16'($urandom_range(0, 6)));
        load_job(arr, $urandom_range(1, 5));
        if ($urandom_range(0, 2) == 0) send(OP_TICK);
      end
      tick_until_idle(200);
      drain(SETTLE);
      phase++;
    end

    apb_write(REG_MODE, 16'(MODE_PRIO_ALT));
    apb_write(REG_SLICE, 16'd4);
    calm_in = 1'b0;
    load_job(16'(sb.now[15:0] + 16'd1), 3);
    load_job(16'(sb.now[15:0] + 16'd2), 4);
    // never arrives; carries wide bursts and overflows the burst store
    send(OP_HDR, 16'($urandom), 8'hFF, 16'hFFFF);
    send(OP_BURST, 0, 0, 0, 16'hFFFF);
    for (int i = 0; i < 34; i++) send(OP_BURST, 0, 0, 0, 16'($urandom));
    send(OP_HDR, 16'h1234, 8'h00, 16'd0);
    while (items_sent < 640) begin
      if (items_sent % 50 == 0) calm_in = ($urandom_range(0, 2) == 0);
      case ($urandom_range(0, 9))
        0: send(OP_NOP, 16'($urandom), 8'($urandom), 16'($urandom), 16'($urandom));
        1: send(OP_BURST, 16'($urandom), 8'($urandom), 16'($urandom), 16'($urandom));
        default: send(OP_TICK, 16'($urandom), 8'($urandom), 16'($urandom), 16'($urandom));
      endcase
    end

    drain(SETTLE);
    $display("Covered %0d items, %0d ticks, %0d dispatches over %0d jobs.",
             items_sent, sb.ticks, sb.dispatches, sb.njobs);
    $display("All four modes and slices from 0 to 65535 were used; %0d mismatches.",
             sb.errors);
    if (sb.errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
